// ===== src/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit-packed integer unpacker package
// Shared widths, codes, beat types and the field width clamp.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int unsigned BufBits        = 72;
  localparam int unsigned WordBits       = 64;
  localparam int unsigned ByteBits       = 8;
  localparam int unsigned CountBits      = 20;
  localparam int unsigned WidthBits      = 7;
  localparam int unsigned ResultLimit    = 8;
  localparam int unsigned ResCntBits     = 4;
  localparam int unsigned MaxFieldBits   = 64;
  localparam int unsigned FieldBitsReset = 8;

  typedef logic [BufBits-1:0]    buf_t;
  typedef logic [WordBits-1:0]   word_t;
  typedef logic [WidthBits-1:0]  held_t;
  typedef logic [CountBits-1:0]  left_t;
  typedef logic [ResCntBits-1:0] rescnt_t;

  // item kinds on the input channel
  typedef enum logic {
    KindStart = 1'b0,
    KindData  = 1'b1
  } kind_e;

  // configuration register indexes
  typedef enum logic {
    RegFieldBits = 1'b0,
    RegFieldMin  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                 kind;
    logic [ByteBits-1:0]  data_byte;
    logic [CountBits-1:0] record_count;
  } in_beat_t;

  typedef struct packed {
    logic signed [WordBits-1:0] value;
    logic                       last;
    logic                       done_res;
  } out_beat_t;

  // one extracted field on its way to the result stage
  typedef struct packed {
    word_t raw;
    logic  last;
    logic  done_res;
  } res_t;

  // clamp the programmed width to 1..MaxFieldBits
  function automatic held_t eff_width(held_t fb);
    held_t w;
    w = fb;
    if (w == '0) w = held_t'(1);
    if (w > held_t'(MaxFieldBits)) w = held_t'(MaxFieldBits);
    return w;
  endfunction

endpackage

// ===== src/bpu_intf.sv =====
// ----------------------------------------------------------------------------
// Bit-packed integer unpacker stream interfaces
// Valid/ready channels for input items and result beats.
// ----------------------------------------------------------------------------
interface bpu_in_if;
  import bpu_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpu_out_if;
  import bpu_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bpu_core.sv =====
// ----------------------------------------------------------------------------
// Bit-packed integer unpacker core
// Holds the bit buffer, appends bytes and extracts one field per cycle while the result stage is ready.
// ----------------------------------------------------------------------------
module bpu_core import bpu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_en_i,
  input  logic     in_valid_i,
  input  in_beat_t in_beat_i,
  input  held_t    width_i,
  output logic     consume_o,
  output logic     res_valid_o,
  output res_t     res_o
);

  buf_t    buf_q, buf_d, app_buf;
  held_t   held_q, held_d, app_held;
  left_t   left_q, left_d;
  rescnt_t cnt_q, cnt_d, app_cnt;
  logic    busy, take, extract, more;
  word_t   mask;

  // field mask, all ones for a full-word field
  assign mask = {WordBits{1'b1}} >> (held_t'(WordBits) - width_i);

  // next state: optional byte append followed by optional extraction
  always_comb begin
    busy     = (left_q != '0) && (held_q >= width_i) && (cnt_q < rescnt_t'(ResultLimit));
    take     = step_en_i && !busy && in_valid_i;
    buf_d    = buf_q;
    held_d   = held_q;
    left_d   = left_q;
    cnt_d    = cnt_q;
    app_buf  = buf_q;
    app_held = held_q;
    app_cnt  = cnt_q;
    extract  = 1'b0;
    if (step_en_i && busy) begin
      extract = 1'b1;
    end else if (take) begin
      if (in_beat_i.kind == KindStart) begin
        buf_d  = '0;
        held_d = '0;
        left_d = in_beat_i.record_count;
        cnt_d  = '0;
      end else if (left_q != '0) begin
        app_buf  = buf_q | (buf_t'(in_beat_i.data_byte) << held_q);
        app_held = (held_q > held_t'(BufBits - ByteBits)) ? held_t'(BufBits)
                                                           : held_q + held_t'(ByteBits);
        app_cnt  = '0;
        buf_d    = app_buf;
        held_d   = app_held;
        // byte with no complete field closes its run at once
        cnt_d    = rescnt_t'(ResultLimit);
        extract  = (app_held >= width_i);
      end
    end
    if (extract) begin
      buf_d  = app_buf >> width_i;
      held_d = app_held - width_i;
      left_d = left_q - left_t'(1);
      cnt_d  = app_cnt + rescnt_t'(1);
    end
    more = (left_d != '0) && (held_d >= width_i) && (cnt_d < rescnt_t'(ResultLimit));
    // the run closes with its last field, held bits wait for the next byte
    if (extract && !more) begin
      cnt_d = rescnt_t'(ResultLimit);
    end
    res_o.raw      = app_buf[WordBits-1:0] & mask;
    res_o.done_res = (left_d == '0);
    res_o.last     = !more;
  end

  assign consume_o   = take;
  assign res_valid_o = extract;

  // buffer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
      left_q <= '0;
      cnt_q  <= '0;
    end else begin
      buf_q  <= buf_d;
      held_q <= held_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
    end
  end

  // buffer never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= held_t'(BufBits))
    else $error("bit count beyond buffer size");

  // no more than the result limit per byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= rescnt_t'(ResultLimit))
    else $error("per-byte result count overrun");

  // a final record leaves nothing to decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_valid_o && res_o.done_res |=> left_q == '0)
    else $error("records left after final record");

endmodule

// ===== src/bpu_result.sv =====
// ----------------------------------------------------------------------------
// Bit-packed integer unpacker result stage
// Field register, minimum offset add and output register.
// ----------------------------------------------------------------------------
module bpu_result import bpu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  res_t             res_i,
  input  word_t            minimum_i,
  output logic             ready_o,
  bpu_out_if.source        out_o
);

  logic      mid_valid_q, out_valid_q;
  res_t      mid_q;
  out_beat_t out_q;
  logic      out_can;

  assign out_can = !out_valid_q || out_o.ready;
  assign ready_o = !mid_valid_q || out_can;

  // field register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (ready_o) begin
      mid_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      mid_q <= res_i;
    end
  end

  // output register with the minimum added, wrapping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_can) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_can && mid_valid_q) begin
      out_q.value    <= mid_q.raw + minimum_i;
      out_q.last     <= mid_q.last;
      out_q.done_res <= mid_q.done_res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== src/bitpacked_integer_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// Bit-packed integer unpacker
// Turns a byte stream of LSB-first packed fields into offset integers.
// ----------------------------------------------------------------------------
// A start beat clears the bit buffer and loads the packet's record count; each
// data beat appends one byte and yields every complete field (at most eight),
// each as field_minimum plus the packed bits, the final record flagged. The
// unpack core takes one byte per cycle, while the result stage is ready, when a
// byte yields at most one field; a byte yielding several fields holds the core
// for one extraction per cycle, so the core's single field extractor sets the
// rate. Start beats and ignored bytes yield no field. A result beat passes the
// input register, unpack core, field register and output register in turn.
// ----------------------------------------------------------------------------
module bitpacked_integer_unpacker_unit import bpu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bpu_in_if.sink       in_i,
  bpu_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i
);

  held_t    field_bits_q;
  word_t    field_min_q;
  logic     in_valid_q;
  in_beat_t in_beat_q;
  logic     step_en, consume, res_valid;
  res_t     res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_bits_q <= held_t'(FieldBitsReset);
      field_min_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegFieldBits: field_bits_q <= cfg_wdata_i[WidthBits-1:0];
        RegFieldMin:  field_min_q  <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // input register
  assign in_i.ready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_beat_q <= in_i.data;
    end
  end

  // unpack core
  bpu_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .in_valid_i  (in_valid_q),
    .in_beat_i   (in_beat_q),
    .width_i     (eff_width(field_bits_q)),
    .consume_o   (consume),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result stage
  bpu_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .minimum_i   (field_min_q),
    .ready_o     (step_en),
    .out_o       (out_o)
  );

endmodule
